// ===== rtl/cqf_slot_offset_allocator_defines.svh =====
// Assertion helpers for the CQF slot offset allocator.
`ifndef CQF_SLOT_OFFSET_ALLOCATOR_DEFINES_SVH
`define CQF_SLOT_OFFSET_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define CQFSOA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet during reset.
`define CQFSOA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cqfsoa_pkg.sv =====
package cqfsoa_pkg;

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_FILL,
        S_MOD,
        S_OFF,
        S_HOP,
        S_RD,
        S_WB,
        S_FIN
    } state_t;

    typedef enum logic [1:0]
    {
        MODE_CHECK,
        MODE_TAKE,
        MODE_GIVE
    } walk_mode_t;

    localparam logic [1:0] OP_ADD_HOP  = 2'd0;
    localparam logic [1:0] OP_SCHEDULE = 2'd1;
    localparam logic [1:0] OP_RELEASE  = 2'd2;
    localparam logic [1:0] OP_CLEAR    = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_FIT    = 2'd1;
    localparam logic [1:0] ST_PATH_FULL = 2'd2;

    localparam logic CFG_SLOT_COUNT = 1'b0;
    localparam logic CFG_QUEUE_CAP  = 1'b1;

    localparam logic [10:0] SLOT_COUNT_RST = 11'd1024;
    localparam logic [7:0]  QUEUE_CAP_RST  = 8'd16;

endpackage

// ===== rtl/cqfsoa_ram.sv =====
module cqfsoa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/cqf_slot_offset_allocator.sv =====
// CQF slot offset allocator: one item at a time, one result beat per item.
// Add hop: goes straight to the finish step. Release: bit-serial remainder of the offset, then each
// hop's cells read and written back. Schedule: per offset tried, each hop's cells read to check the
// fit, the fit walked again to commit; the read/write loop over the free-room RAM sets the pace.
// Clear: one RAM entry per cycle over the whole store, then a result.
// Reset: async, active low; a fill pass over the whole store follows, input not taken meanwhile.
`include "cqf_slot_offset_allocator_defines.svh"

module cqf_slot_offset_allocator #(
    parameter int NODES     = 8,
    parameter int PORTS     = 4,
    parameter int MAX_SLOTS = 1024,
    parameter int MAX_HOPS  = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // item channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [2:0]  hop_node,
    input  logic [1:0]  hop_port,
    input  logic [10:0] period,
    input  logic [10:0] deadline,
    input  logic [7:0]  pkt_count,
    input  logic [9:0]  release_offset,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [9:0]  chosen_offset,
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [10:0] cfg_data
);

    // Store: one entry per (switch, port, slot), laid out switch-major.
    localparam int DEPTH = NODES * PORTS * MAX_SLOTS;
    localparam int AW    = $clog2(DEPTH);
    // Arithmetic width: room for slot_count + period and for offset + hops vs deadline.
    localparam int SCW   = $clog2(MAX_SLOTS + 1);
    localparam int LW    = ((SCW > 11) ? SCW : 11) + 2;
    localparam int HCW   = $clog2(MAX_HOPS + 1);
    localparam int HIW   = (MAX_HOPS > 1) ? $clog2(MAX_HOPS) : 1;

    cqfsoa_pkg::state_t     state_reg, state_next;
    cqfsoa_pkg::walk_mode_t mode_reg;

    // Pending path
    logic [2:0]     path_node_reg [MAX_HOPS];
    logic [1:0]     path_port_reg [MAX_HOPS];
    logic [HCW-1:0] hop_count_reg;

    // Registers
    logic [10:0] slot_count_reg;
    logic [7:0]  queue_cap_reg;

    // Fill pass
    logic [7:0]    fill_val_reg;
    logic [AW-1:0] fill_addr_reg;
    logic          fill_item_reg;   // pass started by a clear beat, so it owes a result

    // Walk context
    logic [LW-1:0]  per_reg;
    logic [LW-1:0]  sc_reg;
    logic [LW-1:0]  dl_reg;
    logic [7:0]     pk_reg;
    logic [LW-1:0]  off_reg;
    logic [LW-1:0]  off1_reg;       // (off + 1) mod slot count
    logic [HCW-1:0] hop_idx_reg;
    logic [LW-1:0]  hop_start_reg;  // (off + hop + 1) mod slot count
    logic [LW-1:0]  slot_reg;
    logic [LW-1:0]  lim_reg;        // (k + 1) * period
    logic [AW-1:0]  base_reg;

    // Bit-serial remainder for the release offset
    logic [3:0]    mod_cnt_reg;
    logic [10:0]   mod_val_reg;
    logic [LW-1:0] mod_rem_reg;

    // Result
    logic [1:0] fin_status_reg;
    logic [9:0] fin_off_reg;
    logic       out_valid_reg;
    logic [1:0] status_reg;
    logic [9:0] chosen_reg;

    // RAM port
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    // Datapath terms
    logic [LW-1:0] sc_eff;
    logic [LW-1:0] per_eff;
    logic [AW-1:0] cell_addr;
    logic          cell_fail;
    logic [LW-1:0] slot_adv;
    logic [LW-1:0] slot_wrap;
    logic [LW-1:0] lim_adv;
    logic          k_more;
    logic [LW-1:0] hs_inc;
    logic [LW-1:0] hs_wrap;
    logic [LW-1:0] off1_inc;
    logic [LW-1:0] off1_wrap;
    logic          walk_done;
    logic          too_late;
    logic          off_end;
    logic [LW-1:0] rem_sh;
    logic [LW-1:0] rem_new;
    logic          mod_last;
    logic          fill_last;
    logic          out_free;
    logic [2:0]    node_sel;
    logic [1:0]    port_sel;
    logic [AW-1:0] base_next;
    logic [7:0]    room_take;
    logic [8:0]    room_sum;
    logic [7:0]    room_give;
    logic          in_beat;

    cqfsoa_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_room (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_beat   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;

    // Slot count and period clamped to 1 .. MAX_SLOTS
    always_comb
    begin
        if (slot_count_reg == 11'd0)
            sc_eff = LW'(1);
        else if (LW'(slot_count_reg) > LW'(MAX_SLOTS))
            sc_eff = LW'(MAX_SLOTS);
        else
            sc_eff = LW'(slot_count_reg);

        if (period == 11'd0)
            per_eff = LW'(1);
        else if (LW'(period) > LW'(MAX_SLOTS))
            per_eff = LW'(MAX_SLOTS);
        else
            per_eff = LW'(period);
    end

    // Cell base of the current hop; out-of-range indexes clamp to the last one
    always_comb
    begin
        node_sel = path_node_reg[hop_idx_reg[HIW-1:0]];
        port_sel = path_port_reg[hop_idx_reg[HIW-1:0]];
        if (32'(node_sel) >= NODES)
            node_sel = 3'(NODES - 1);
        if (32'(port_sel) >= PORTS)
            port_sel = 2'(PORTS - 1);
        base_next = AW'((32'(node_sel) * PORTS + 32'(port_sel)) * MAX_SLOTS);
    end

    assign cell_addr = base_reg + AW'(slot_reg);
    assign cell_fail = ram_rdata < pk_reg;

    // slot < sc and period <= sc whenever cells are walked: one subtract wraps
    assign slot_adv  = slot_reg + per_reg;
    assign slot_wrap = (slot_adv >= sc_reg) ? slot_adv - sc_reg : slot_adv;
    assign lim_adv   = lim_reg + per_reg;
    assign k_more    = lim_adv <= sc_reg;
    assign hs_inc    = hop_start_reg + LW'(1);
    assign hs_wrap   = (hs_inc >= sc_reg) ? '0 : hs_inc;
    assign off1_inc  = off1_reg + LW'(1);
    assign off1_wrap = (off1_inc >= sc_reg) ? '0 : off1_inc;

    // No hops left, or the period exceeds the cycle so no slot repeats
    assign walk_done = (hop_idx_reg >= hop_count_reg) || (per_reg > sc_reg);
    assign off_end   = off_reg >= per_reg;
    assign too_late  = (off_reg + LW'(hop_count_reg) + LW'(1)) > dl_reg;

    assign rem_sh    = {mod_rem_reg[LW-2:0], mod_val_reg[10]};
    assign rem_new   = (rem_sh >= sc_reg) ? rem_sh - sc_reg : rem_sh;
    assign mod_last  = mod_cnt_reg == 4'd10;
    assign fill_last = fill_addr_reg == AW'(DEPTH - 1);

    assign room_take = (ram_rdata >= pk_reg) ? ram_rdata - pk_reg : 8'd0;
    assign room_sum  = {1'b0, ram_rdata} + {1'b0, pk_reg};
    assign room_give = (room_sum > {1'b0, queue_cap_reg}) ? queue_cap_reg : room_sum[7:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cqfsoa_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (opcode)
                        cqfsoa_pkg::OP_ADD_HOP:  state_next = cqfsoa_pkg::S_FIN;
                        cqfsoa_pkg::OP_SCHEDULE: state_next = cqfsoa_pkg::S_OFF;
                        cqfsoa_pkg::OP_RELEASE:  state_next = cqfsoa_pkg::S_MOD;
                        cqfsoa_pkg::OP_CLEAR:    state_next = cqfsoa_pkg::S_FILL;
                        default:                 state_next = cqfsoa_pkg::S_IDLE;
                    endcase
                end
            end
            cqfsoa_pkg::S_FILL:
            begin
                if (fill_last)
                    state_next = fill_item_reg ? cqfsoa_pkg::S_FIN : cqfsoa_pkg::S_IDLE;
            end
            cqfsoa_pkg::S_MOD:
            begin
                if (mod_last)
                    state_next = cqfsoa_pkg::S_HOP;
            end
            cqfsoa_pkg::S_OFF:
            begin
                if (off_end || too_late)
                    state_next = cqfsoa_pkg::S_FIN;
                else
                    state_next = cqfsoa_pkg::S_HOP;
            end
            cqfsoa_pkg::S_HOP:
            begin
                if (!walk_done)
                    state_next = cqfsoa_pkg::S_RD;
                else if (mode_reg != cqfsoa_pkg::MODE_CHECK)
                    state_next = cqfsoa_pkg::S_FIN;
            end
            cqfsoa_pkg::S_RD:
            begin
                state_next = cqfsoa_pkg::S_WB;
            end
            cqfsoa_pkg::S_WB:
            begin
                if (mode_reg == cqfsoa_pkg::MODE_CHECK && cell_fail)
                    state_next = cqfsoa_pkg::S_OFF;
                else if (k_more)
                    state_next = cqfsoa_pkg::S_RD;
                else
                    state_next = cqfsoa_pkg::S_HOP;
            end
            cqfsoa_pkg::S_FIN:
            begin
                if (out_free)
                    state_next = cqfsoa_pkg::S_IDLE;
            end
            default:
            begin
                state_next = cqfsoa_pkg::S_IDLE;
            end
        endcase
    end

    // Handshake and RAM controls. A cell write lands before the
    // next read is issued, so read-modify-write needs no forwarding.
    always_comb
    begin
        in_ready  = state_reg == cqfsoa_pkg::S_IDLE;
        ram_raddr = cell_addr;
        ram_we    = 1'b0;
        ram_waddr = cell_addr;
        ram_wdata = room_give;
        unique case (state_reg)
            cqfsoa_pkg::S_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = fill_addr_reg;
                ram_wdata = fill_val_reg;
            end
            cqfsoa_pkg::S_WB:
            begin
                ram_we    = mode_reg != cqfsoa_pkg::MODE_CHECK;
                ram_wdata = (mode_reg == cqfsoa_pkg::MODE_TAKE) ? room_take : room_give;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= cqfsoa_pkg::S_FILL;
            hop_count_reg  <= '0;
            slot_count_reg <= cqfsoa_pkg::SLOT_COUNT_RST;
            queue_cap_reg  <= cqfsoa_pkg::QUEUE_CAP_RST;
            fill_val_reg   <= cqfsoa_pkg::QUEUE_CAP_RST;
            fill_addr_reg  <= '0;
            fill_item_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            mode_reg       <= cqfsoa_pkg::MODE_CHECK;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    cqfsoa_pkg::CFG_SLOT_COUNT: slot_count_reg <= cfg_data;
                    cqfsoa_pkg::CFG_QUEUE_CAP:  queue_cap_reg  <= cfg_data[7:0];
                    default:                    slot_count_reg <= slot_count_reg;
                endcase
            end

            // Load on a finished item, drop once the beat is taken
            if (state_reg == cqfsoa_pkg::S_FIN && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                cqfsoa_pkg::S_IDLE:
                begin
                    if (in_beat)
                    begin
                        fin_status_reg <= cqfsoa_pkg::ST_OK;
                        fin_off_reg    <= '0;
                        per_reg        <= per_eff;
                        sc_reg         <= sc_eff;
                        dl_reg         <= LW'(deadline);
                        pk_reg         <= pkt_count;
                        off_reg        <= '0;
                        off1_reg       <= (sc_eff == LW'(1)) ? '0 : LW'(1);
                        unique case (opcode)
                            cqfsoa_pkg::OP_ADD_HOP:
                            begin
                                if (hop_count_reg >= HCW'(MAX_HOPS))
                                    fin_status_reg <= cqfsoa_pkg::ST_PATH_FULL;
                                else
                                begin
                                    path_node_reg[hop_count_reg[HIW-1:0]] <= hop_node;
                                    path_port_reg[hop_count_reg[HIW-1:0]] <= hop_port;
                                    hop_count_reg <= hop_count_reg + HCW'(1);
                                end
                            end
                            cqfsoa_pkg::OP_SCHEDULE:
                            begin
                                mode_reg <= cqfsoa_pkg::MODE_CHECK;
                            end
                            cqfsoa_pkg::OP_RELEASE:
                            begin
                                mode_reg    <= cqfsoa_pkg::MODE_GIVE;
                                mod_val_reg <= {1'b0, release_offset} + 11'd1;
                                mod_rem_reg <= '0;
                                mod_cnt_reg <= '0;
                            end
                            cqfsoa_pkg::OP_CLEAR:
                            begin
                                fill_val_reg  <= queue_cap_reg;
                                fill_addr_reg <= '0;
                                fill_item_reg <= 1'b1;
                                hop_count_reg <= '0;
                            end
                            default:
                            begin
                                mode_reg <= cqfsoa_pkg::MODE_CHECK;
                            end
                        endcase
                    end
                end
                cqfsoa_pkg::S_FILL:
                begin
                    fill_addr_reg <= fill_addr_reg + AW'(1);
                end
                cqfsoa_pkg::S_MOD:
                begin
                    // (release_offset + 1) mod slot count, one bit a cycle
                    mod_rem_reg <= rem_new;
                    mod_val_reg <= {mod_val_reg[9:0], 1'b0};
                    mod_cnt_reg <= mod_cnt_reg + 4'd1;
                    hop_idx_reg <= '0;
                    lim_reg     <= per_reg;
                    if (mod_last)
                    begin
                        hop_start_reg <= rem_new;
                        slot_reg      <= rem_new;
                    end
                end
                cqfsoa_pkg::S_OFF:
                begin
                    hop_idx_reg   <= '0;
                    hop_start_reg <= off1_reg;
                    slot_reg      <= off1_reg;
                    lim_reg       <= per_reg;
                    if (off_end || too_late)
                    begin
                        fin_status_reg <= cqfsoa_pkg::ST_NO_FIT;
                        hop_count_reg  <= '0;
                    end
                end
                cqfsoa_pkg::S_HOP:
                begin
                    base_reg <= base_next;
                    if (walk_done)
                    begin
                        if (mode_reg == cqfsoa_pkg::MODE_CHECK)
                        begin
                            // every cell fits: walk again and commit
                            mode_reg      <= cqfsoa_pkg::MODE_TAKE;
                            hop_idx_reg   <= '0;
                            hop_start_reg <= off1_reg;
                            slot_reg      <= off1_reg;
                            lim_reg       <= per_reg;
                        end
                        else
                        begin
                            hop_count_reg <= '0;
                            if (mode_reg == cqfsoa_pkg::MODE_TAKE)
                                fin_off_reg <= off_reg[9:0];
                        end
                    end
                end
                cqfsoa_pkg::S_WB:
                begin
                    if (mode_reg == cqfsoa_pkg::MODE_CHECK && cell_fail)
                    begin
                        off_reg  <= off_reg + LW'(1);
                        off1_reg <= off1_wrap;
                    end
                    else if (k_more)
                    begin
                        slot_reg <= slot_wrap;
                        lim_reg  <= lim_adv;
                    end
                    else
                    begin
                        hop_idx_reg   <= hop_idx_reg + HCW'(1);
                        hop_start_reg <= hs_wrap;
                        slot_reg      <= hs_wrap;
                        lim_reg       <= per_reg;
                    end
                end
                cqfsoa_pkg::S_FIN:
                begin
                    if (out_free)
                    begin
                        status_reg    <= fin_status_reg;
                        chosen_reg    <= fin_off_reg;
                        fill_item_reg <= 1'b0;
                    end
                end
                default:
                begin
                    fill_item_reg <= fill_item_reg;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign chosen_offset = chosen_reg;

    // Store writes only from the fill pass or the write-back step
    `CQFSOA_ASSERT_IMP(a_we_state, ram_we,
        (state_reg == cqfsoa_pkg::S_WB) || (state_reg == cqfsoa_pkg::S_FILL),
        "store written outside fill or write-back")
    // A cell read always lies inside the cycle
    `CQFSOA_ASSERT_IMP(a_slot_range, state_reg == cqfsoa_pkg::S_RD, slot_reg < sc_reg,
        "slot index beyond slot count")
    // Path never grows past its buffer
    `CQFSOA_ASSERT_IMP(a_hop_bound, 1'b1, hop_count_reg <= HCW'(MAX_HOPS),
        "hop count beyond path buffer")
    // A finished item is handed to the output register at once when it is free
    `CQFSOA_ASSERT_NXT(a_fin_load, (state_reg == cqfsoa_pkg::S_FIN) && out_free,
        out_valid_reg && (state_reg == cqfsoa_pkg::S_IDLE),
        "result not loaded")

endmodule
